// ===== design/swm_pkg.sv =====
// Package for the sliding window minimum block.
// Holds the shared sample width, the count width and the scan token type.
// No dependencies.
package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;
  // Wide enough for any window count up to the largest supported depth.
  localparam int TOK_CNT_W      = 11;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic                 vld;
    sample_t              min;
    logic [TOK_CNT_W-1:0] cnt;
  } swm_token_t;

endpackage

// ===== design/sliding_window_minimum.sv =====
// Top level of the sliding window minimum block.
// Instantiates a chain of swm_cell stages; depends on swm_pkg.
//
// Usage:
//   Samples arrive on the in_ stream: in_tdata carries the signed sample and
//   in_tuser marks the first sample of a new sequence. A request is taken when
//   in_tvalid and in_tready are both high. Results leave on the out_ stream as
//   the signed minimum of the most recent window_size samples of the current
//   sequence. Until a sequence has supplied a full window, its samples give no
//   result. The window size is written through cfg_we / cfg_wdata while idle;
//   zero counts as one and values above MAX_WINDOW are clamped.
// Timing:
//   Stored samples sit in a shift line of MAX_WINDOW cells. Each request that
//   gives a result launches a token that walks the whole chain, one cell per
//   cycle, folding in the samples it still has to cover. The result reaches
//   the output register after the launch register and every cell's token
//   register; the block takes no new request until that result has been taken,
//   so a request with a result holds off the next one for the whole scan plus
//   any output stall. A request that gives no result leaves the block ready.
// Reset:
//   Synchronous active-low reset clears the fill count, all tokens and the
//   output valid, and sets the window size to one. Stored samples are not
//   cleared; they are only read once the sequence has written them.
module sliding_window_minimum #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0] in_tdata,  // [31:0] sample_value
  input  logic                        in_tuser,  // [0] sequence_start
  // Result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [swm_pkg::SAMPLE_W-1:0] out_tdata, // [31:0] window_min
  // Configuration
  input  logic                        cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wdata  // window_size
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0]     wsz_r;
  logic [CW-1:0]        fill_r;
  logic [CW-1:0]        fill_nxt;
  logic [CW-1:0]        fill_base;
  logic                 busy_r;
  logic                 out_valid_r;
  sample_t              out_data_r;
  swm_token_t           launch_r;
  logic [TOK_CNT_W-1:0] w_eff;
  logic                 in_acc;
  logic                 out_acc;
  logic                 emit;

  sample_t              val_w [MAX_WINDOW];
  swm_token_t           tok_w [MAX_WINDOW+1];
  logic [MAX_WINDOW:0]  tok_vld;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Effective window: zero behaves as one, anything beyond the depth is clamped.
  always_comb begin
    if (wsz_r == '0) begin
      w_eff = TOK_CNT_W'(1);
    end else if (TOK_CNT_W'(wsz_r) > TOK_CNT_W'(MAX_WINDOW)) begin
      w_eff = TOK_CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = TOK_CNT_W'(wsz_r);
    end
  end

  // The fill count restarts on a sequence start and saturates at the depth.
  always_comb begin
    fill_base = in_tuser ? '0 : fill_r;
    if (TOK_CNT_W'(fill_base) < TOK_CNT_W'(MAX_WINDOW)) begin
      fill_nxt = fill_base + CW'(1);
    end else begin
      fill_nxt = fill_base;
    end
    emit = (TOK_CNT_W'(fill_nxt) >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r <= CFG_W'(1);
    end else if (cfg_we) begin
      wsz_r <= cfg_wdata;
    end
  end

  // The token starts with the new sample as its minimum and the window as its count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      busy_r       <= 1'b0;
      launch_r.vld <= 1'b0;
    end else begin
      launch_r.vld <= 1'b0;
      if (in_acc) begin
        fill_r       <= fill_nxt;
        launch_r.min <= sample_t'(in_tdata);
        launch_r.cnt <= w_eff;
        if (emit) begin
          busy_r       <= 1'b1;
          launch_r.vld <= 1'b1;
        end
      end else if (out_acc) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign tok_w[0] = launch_r;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    sample_t val_src;
    if (k == 0) begin : g_head
      assign val_src = sample_t'(in_tdata);
    end else begin : g_body
      assign val_src = val_w[k-1];
    end
    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .val_in   (val_src),
      .val_out  (val_w[k]),
      .tok_in   (tok_w[k]),
      .tok_out  (tok_w[k+1])
    );
  end

  for (genvar k = 0; k <= MAX_WINDOW; k++) begin : g_vld
    assign tok_vld[k] = tok_w[k].vld;
  end

  // The token leaving the last cell lands in the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_w[MAX_WINDOW].vld) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_w[MAX_WINDOW].vld) begin
      out_data_r <= tok_w[MAX_WINDOW].min;
    end
  end

  assign in_tready  = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Only one token may be in flight along the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_vld))
    else $error("more than one minimum token in the chain");

  // A token leaving the chain never finds an unread result in the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[MAX_WINDOW].vld |-> !out_valid_r)
    else $error("result overwritten before it was taken");

  // Tokens and pending results exist only while the block is busy.
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    ((|tok_vld) || out_valid_r) |-> busy_r)
    else $error("token or result present while idle");

  // Stored samples do not move while a token is walking the chain.
  a_hold_values: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vld) |-> !in_acc)
    else $error("request accepted during a scan");

endmodule

// ===== design/swm_cell.sv =====
// One cell of the sliding window minimum chain.
// Holds one stored sample and one stage of the travelling minimum token.
// Depends on swm_pkg.
module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  swm_pkg::sample_t   val_in,
  output swm_pkg::sample_t   val_out,
  input  swm_pkg::swm_token_t tok_in,
  output swm_pkg::swm_token_t tok_out
);
  import swm_pkg::*;

  sample_t    val_r;
  swm_token_t tok_r;
  swm_token_t tok_nxt;

  // A token with count left folds this cell's sample in; otherwise it passes on.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && (tok_in.cnt != '0)) begin
      tok_nxt.cnt = tok_in.cnt - TOK_CNT_W'(1);
      if (val_r < tok_in.min) begin
        tok_nxt.min = val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign val_out = val_r;
  assign tok_out = tok_r;

endmodule
